/* rtl/hpc_pkg.sv */
// Shared constants and helpers for the haversine proximity check unit.
`timescale 1ns / 1ps
package hpc_pkg;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int DIST_W  = 25;
    localparam int ANG_W   = 31;
    localparam int ROOT_W  = 31;
    localparam int CORDIC_W = 34;

    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] GAIN_Q30    = 31'd652032874;
    localparam logic [23:0] EARTH_DIAM_M = 24'd12742000;
    localparam logic [DIST_W-1:0] LIMIT_RESET = 25'd600;

    localparam logic signed [34:0] DEG90_U  = 35'sd900000000;
    localparam logic signed [34:0] DEG180_U = 35'sd1800000000;
    localparam logic signed [34:0] DEG360_U = 35'sd3600000000;

    // Angle scaling: ang = floor(r * K / DIV), estimated as (r * RECIP) >> 32 and corrected once.
    localparam logic [30:0] DIV_U   = 31'd1800000000;
    localparam logic [31:0] K_HALF  = 32'd1686629713;
    localparam logic [31:0] K_FULL  = 32'd3373259426;
    localparam logic [63:0] RECIP_HALF_W = (64'd1686629713 << 32) / 64'd1800000000;
    localparam logic [63:0] RECIP_FULL_W = (64'd3373259426 << 32) / 64'd1800000000;
    localparam logic [32:0] RECIP_HALF = RECIP_HALF_W[32:0];
    localparam logic [32:0] RECIP_FULL = RECIP_FULL_W[32:0];

    localparam int CHANNELS = 4;

    function automatic logic [30:0] atan_q30(input int i);
        logic [30:0] v;
        case (i)
            0:  v = 31'd843314856;
            1:  v = 31'd497837829;
            2:  v = 31'd263043836;
            3:  v = 31'd133525158;
            4:  v = 31'd67021686;
            5:  v = 31'd33543515;
            6:  v = 31'd16775850;
            7:  v = 31'd8388437;
            8:  v = 31'd4194282;
            9:  v = 31'd2097149;
            10: v = 31'd1048575;
            11: v = 31'd524287;
            12: v = 31'd262143;
            13: v = 31'd131071;
            14: v = 31'd65535;
            15: v = 31'd32767;
            16: v = 31'd16383;
            17: v = 31'd8191;
            18: v = 31'd4095;
            19: v = 31'd2047;
            20: v = 31'd1023;
            21: v = 31'd511;
            22: v = 31'd255;
            23: v = 31'd127;
            24: v = 31'd63;
            25: v = 31'd31;
            26: v = 31'd15;
            27: v = 31'd7;
            28: v = 31'd3;
            29: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    // Clamp a CORDIC output to [0, 1.0].
    function automatic logic [30:0] clamp_unit(input logic signed [CORDIC_W-1:0] v);
        logic [30:0] r;
        if (v[CORDIC_W-1])
            r = 31'd0;
        else if (v > $signed({3'b0, ONE_Q30}))
            r = ONE_Q30;
        else
            r = v[30:0];
        return r;
    endfunction

endpackage

/* rtl/hpc_if.sv */
// Valid/ready channel interfaces for point pairs and distance results.
`timescale 1ns / 1ps
interface hpc_in_if;
    logic valid;
    logic ready;
    logic signed [30:0] ref_lat;
    logic signed [31:0] ref_lon;
    logic signed [30:0] pt_lat;
    logic signed [31:0] pt_lon;

    modport source (output valid, output ref_lat, output ref_lon, output pt_lat,
                    output pt_lon, input ready);
    modport sink (input valid, input ref_lat, input ref_lon, input pt_lat,
                  input pt_lon, output ready);
endinterface

interface hpc_out_if;
    logic valid;
    logic ready;
    logic [24:0] distance_m;
    logic within_range;

    modport source (output valid, output distance_m, output within_range, input ready);
    modport sink (input valid, input distance_m, input within_range, output ready);
endinterface

/* rtl/hpc_cordic.sv */
// Fully pipelined CORDIC, one register stage per iteration, rotation or vectoring mode.
`timescale 1ns / 1ps
module hpc_cordic
    import hpc_pkg::*;
#(
    parameter int STAGES    = 24,
    parameter bit VECTORING = 1'b0
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [CORDIC_W-1:0] x_in,
    input  logic signed [CORDIC_W-1:0] y_in,
    input  logic signed [CORDIC_W-1:0] z_in,
    output logic signed [CORDIC_W-1:0] x_out,
    output logic signed [CORDIC_W-1:0] y_out,
    output logic signed [CORDIC_W-1:0] z_out
);

    logic signed [CORDIC_W-1:0] x_reg [STAGES];
    logic signed [CORDIC_W-1:0] y_reg [STAGES];
    logic signed [CORDIC_W-1:0] z_reg [STAGES];
    logic signed [CORDIC_W-1:0] x_next [STAGES];
    logic signed [CORDIC_W-1:0] y_next [STAGES];
    logic signed [CORDIC_W-1:0] z_next [STAGES];

    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            logic signed [CORDIC_W-1:0] xp;
            logic signed [CORDIC_W-1:0] yp;
            logic signed [CORDIC_W-1:0] zp;
            logic signed [CORDIC_W-1:0] xs;
            logic signed [CORDIC_W-1:0] ys;
            logic signed [CORDIC_W-1:0] at;
            logic up;
            if (i == 0)
            begin
                xp = x_in;
                yp = y_in;
                zp = z_in;
            end
            else
            begin
                xp = x_reg[i-1];
                yp = y_reg[i-1];
                zp = z_reg[i-1];
            end
            xs = xp >>> i;
            ys = yp >>> i;
            at = $signed({3'b0, atan_q30(i)});
            // rotation follows the residual angle, vectoring drives y to zero
            up = VECTORING ? yp[CORDIC_W-1] : !zp[CORDIC_W-1];
            if (up)
            begin
                x_next[i] = xp - ys;
                y_next[i] = yp + xs;
                z_next[i] = zp - at;
            end
            else
            begin
                x_next[i] = xp + ys;
                y_next[i] = yp - xs;
                z_next[i] = zp + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    assign x_out = x_reg[STAGES-1];
    assign y_out = y_reg[STAGES-1];
    assign z_out = z_reg[STAGES-1];

endmodule

/* rtl/haversine_proximity_check_unit.sv */
// Top level: haversine great-circle distance and range check, fully pipelined.
// Takes one point pair per cycle while the skid register is empty and returns one result
// per pair in order. A pair passes five stages of angle reduction and scaling, the two
// CORDIC chains (one register per iteration), three multiply stages, a 31-stage square
// root with one result bit per stage, a scale stage, a compare stage and the output
// register. While the skid register holds a result the whole pipeline and the input stay
// frozen; nothing is dropped. limit_reg resets to 600 and is written through
// wr_en/wr_data; write it only while no pair is in flight, the block does not enforce it.
`timescale 1ns / 1ps
module haversine_proximity_check_unit
    import hpc_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    hpc_in_if.sink            points,
    hpc_out_if.source         result,
    input  logic              wr_en,
    input  logic [DIST_W-1:0] wr_data
);

    localparam int SQ_STAGES = ROOT_W;
    localparam int LAT       = 5 + CORDIC_STAGES + 3 + SQ_STAGES + CORDIC_STAGES + 2;
    localparam int NEG_LEN   = 4 + CORDIC_STAGES;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [DIST_W-1:0] limit_reg;

    // ---------------- S1: differences and magnitudes ----------------
    logic signed [31:0] dlat_reg, dlat_next;
    logic signed [32:0] dlon_reg, dlon_next;
    logic [30:0] alat_r_reg, alat_r_next, alat_p_reg, alat_p_next;

    function automatic logic [30:0] abs_lat(input logic signed [30:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        if (w < 0)
            w = -w;
        return w[30:0];
    endfunction

    always_comb
    begin
        dlat_next   = 32'(points.pt_lat) - 32'(points.ref_lat);
        dlon_next   = 33'(points.pt_lon) - 33'(points.ref_lon);
        alat_r_next = abs_lat(points.ref_lat);
        alat_p_next = abs_lat(points.pt_lat);
    end

    // ---------------- S2: reduce and fold ----------------
    function automatic logic [30:0] half_reduce(input logic signed [34:0] d);
        logic signed [34:0] t;
        t = d;
        if (t < 0)
            t = t + DEG360_U;
        if (t < 0)
            t = t + DEG360_U;
        if (t >= DEG360_U)
            t = t - DEG360_U;
        if (t > DEG180_U)
            t = DEG360_U - t;
        return t[30:0];
    endfunction

    function automatic logic [31:0] cos_fold(input logic [30:0] a);
        logic signed [34:0] t;
        logic neg;
        t   = 35'(a);
        neg = 1'b0;
        if (t > DEG90_U)
        begin
            t   = DEG180_U - t;
            neg = 1'b1;
        end
        return {neg, t[30:0]};
    endfunction

    logic [30:0] red_reg [CHANNELS];
    logic [30:0] red_next [CHANNELS];
    logic [NEG_LEN-1:0] neg_reg;
    logic neg_next;
    logic [31:0] fold_r, fold_p;

    always_comb
    begin
        fold_r      = cos_fold(alat_r_reg);
        fold_p      = cos_fold(alat_p_reg);
        red_next[0] = half_reduce(35'(dlat_reg));
        red_next[1] = half_reduce(35'(dlon_reg));
        red_next[2] = fold_r[30:0];
        red_next[3] = fold_p[30:0];
        neg_next    = fold_r[31] ^ fold_p[31];
    end

    // ---------------- S3..S5: scale to Q1.30 radians ----------------
    logic [61:0] prod_reg [CHANNELS];
    logic [61:0] prod_next [CHANNELS];
    logic [30:0] q0_reg [CHANNELS];
    logic [30:0] q0_next [CHANNELS];
    logic [61:0] p4_reg [CHANNELS];
    logic [61:0] qd_reg [CHANNELS];
    logic [61:0] qd_next [CHANNELS];
    logic [30:0] q4_reg [CHANNELS];
    logic [30:0] ang_reg [CHANNELS];
    logic [30:0] ang_next [CHANNELS];

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            logic [31:0] k;
            logic [32:0] m;
            logic [63:0] e;
            logic [61:0] rem;
            k = (c < 2) ? K_HALF : K_FULL;
            m = (c < 2) ? RECIP_HALF : RECIP_FULL;
            prod_next[c] = {31'b0, red_reg[c]} * {30'b0, k};
            e            = {33'b0, red_reg[c]} * {31'b0, m};
            q0_next[c]   = e[62:32];
            qd_next[c]   = {31'b0, q0_reg[c]} * {31'b0, DIV_U};
            rem          = p4_reg[c] - qd_reg[c];
            // estimate is at most one low
            ang_next[c]  = (rem >= 62'(DIV_U)) ? q4_reg[c] + 31'd1 : q4_reg[c];
        end
    end

    // ---------------- CORDIC rotation: sin of half differences, cos of latitudes ----------------
    logic signed [CORDIC_W-1:0] rx [CHANNELS];
    logic signed [CORDIC_W-1:0] ry [CHANNELS];
    logic signed [CORDIC_W-1:0] rz [CHANNELS];

    genvar gc;
    generate
        for (gc = 0; gc < CHANNELS; gc++)
        begin : g_rot
            hpc_cordic #(
                .STAGES    (CORDIC_STAGES),
                .VECTORING (1'b0)
            ) u_rot (
                .clk   (clk),
                .en    (en),
                .x_in  ($signed({3'b0, GAIN_Q30})),
                .y_in  ('0),
                .z_in  ($signed({3'b0, ang_reg[gc]})),
                .x_out (rx[gc]),
                .y_out (ry[gc]),
                .z_out (rz[gc])
            );
        end
    endgenerate

    // ---------------- Sa, Sb, Sc: combine into a ----------------
    logic [30:0] slat_reg, slat_next, slon_reg, slon_next, cc_reg, cc_next;
    logic neg_a_reg, neg_b_reg;
    logic [30:0] slat_b_reg, t_reg, t_next;
    logic [30:0] a_reg, a_next, b_reg, b_next;
    logic [30:0] s0, s1, c2, c3;
    logic [61:0] sq0, sq1, ccp, tp;
    logic signed [32:0] sum;

    always_comb
    begin
        s0 = clamp_unit(ry[0]);
        s1 = clamp_unit(ry[1]);
        c2 = clamp_unit(rx[2]);
        c3 = clamp_unit(rx[3]);
        sq0 = {31'b0, s0} * {31'b0, s0};
        sq1 = {31'b0, s1} * {31'b0, s1};
        ccp = {31'b0, c2} * {31'b0, c3};
        slat_next = sq0[60:30];
        slon_next = sq1[60:30];
        cc_next   = ccp[60:30];
        tp     = {31'b0, slon_reg} * {31'b0, cc_reg};
        t_next = tp[60:30];
        if (neg_b_reg)
            sum = $signed({2'b0, slat_b_reg}) - $signed({2'b0, t_reg});
        else
            sum = $signed({2'b0, slat_b_reg}) + $signed({2'b0, t_reg});
        if (sum[32])
            a_next = 31'd0;
        else if (sum > $signed({2'b0, ONE_Q30}))
            a_next = ONE_Q30;
        else
            a_next = sum[30:0];
        b_next = ONE_Q30 - a_next;
    end

    // ---------------- square roots, one result bit per stage ----------------
    logic [61:0] rem_reg [2][SQ_STAGES];
    logic [61:0] rem_next [2][SQ_STAGES];
    logic [30:0] root_reg [2][SQ_STAGES];
    logic [30:0] root_next [2][SQ_STAGES];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            for (int j = 0; j < SQ_STAGES; j++)
            begin
                logic [61:0] rp;
                logic [30:0] qp;
                logic [62:0] trial;
                if (j == 0)
                begin
                    rp = (l == 0) ? {1'b0, a_reg, 30'b0} : {1'b0, b_reg, 30'b0};
                    qp = 31'd0;
                end
                else
                begin
                    rp = rem_reg[l][j-1];
                    qp = root_reg[l][j-1];
                end
                trial = (63'(qp) << (SQ_STAGES - j)) + (63'd1 << (2 * (SQ_STAGES - 1 - j)));
                if (trial <= 63'(rp))
                begin
                    rem_next[l][j]  = rp - trial[61:0];
                    root_next[l][j] = qp | (31'd1 << (SQ_STAGES - 1 - j));
                end
                else
                begin
                    rem_next[l][j]  = rp;
                    root_next[l][j] = qp;
                end
            end
        end
    end

    // ---------------- CORDIC vectoring: atan2(sqrt(a), sqrt(1-a)) ----------------
    logic signed [CORDIC_W-1:0] vx, vy, vz;

    hpc_cordic #(
        .STAGES    (CORDIC_STAGES),
        .VECTORING (1'b1)
    ) u_vec (
        .clk   (clk),
        .en    (en),
        .x_in  ($signed({3'b0, root_reg[1][SQ_STAGES-1]})),
        .y_in  ($signed({3'b0, root_reg[0][SQ_STAGES-1]})),
        .z_in  ('0),
        .x_out (vx),
        .y_out (vy),
        .z_out (vz)
    );

    // ---------------- Se, Sf: scale to meters and compare ----------------
    logic [30:0] zc;
    logic [54:0] dprod_reg, dprod_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic near_reg, near_next;

    always_comb
    begin
        if (vz[CORDIC_W-1])
            zc = 31'd0;
        else if (vz > $signed({3'b0, HALF_PI_Q30}))
            zc = HALF_PI_Q30;
        else
            zc = vz[30:0];
        dprod_next = {24'b0, zc} * {31'b0, EARTH_DIAM_M};
        dist_next  = dprod_reg[54:30];
        near_next  = (dist_next <= limit_reg);
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlat_reg   <= dlat_next;
            dlon_reg   <= dlon_next;
            alat_r_reg <= alat_r_next;
            alat_p_reg <= alat_p_next;
            neg_reg    <= {neg_reg[NEG_LEN-2:0], neg_next};
            for (int c = 0; c < CHANNELS; c++)
            begin
                red_reg[c]  <= red_next[c];
                prod_reg[c] <= prod_next[c];
                q0_reg[c]   <= q0_next[c];
                p4_reg[c]   <= prod_reg[c];
                qd_reg[c]   <= qd_next[c];
                q4_reg[c]   <= q0_reg[c];
                ang_reg[c]  <= ang_next[c];
            end
            slat_reg   <= slat_next;
            slon_reg   <= slon_next;
            cc_reg     <= cc_next;
            neg_a_reg  <= neg_reg[NEG_LEN-1];
            slat_b_reg <= slat_reg;
            t_reg      <= t_next;
            neg_b_reg  <= neg_a_reg;
            a_reg      <= a_next;
            b_reg      <= b_next;
            for (int l = 0; l < 2; l++)
            begin
                for (int j = 0; j < SQ_STAGES; j++)
                begin
                    rem_reg[l][j]  <= rem_next[l][j];
                    root_reg[l][j] <= root_next[l][j];
                end
            end
            dprod_reg <= dprod_next;
            dist_reg  <= dist_next;
            near_reg  <= near_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], points.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (wr_en)
            limit_reg <= wr_data;
    end

    // ---------------- output register and skid ----------------
    logic out_v_reg, skid_v_reg;
    logic [DIST_W-1:0] out_dist_reg, skid_dist_reg;
    logic out_near_reg, skid_near_reg;
    logic push, out_fire;

    assign en       = !skid_v_reg;
    assign push     = en && vld_reg[LAT-1];
    assign out_fire = out_v_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_fire)
                skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_v_reg || out_fire)
                out_v_reg <= 1'b1;
            else
                skid_v_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_fire)
            begin
                out_dist_reg <= skid_dist_reg;
                out_near_reg <= skid_near_reg;
            end
        end
        else if (push)
        begin
            // load the new result, or hold the waiting result and park the new one
            if (!out_v_reg || out_fire)
            begin
                out_dist_reg <= dist_reg;
                out_near_reg <= near_reg;
            end
            else
            begin
                skid_dist_reg <= dist_reg;
                skid_near_reg <= near_reg;
            end
        end
    end

    assign points.ready        = en;
    assign result.valid        = out_v_reg;
    assign result.distance_m   = out_dist_reg;
    assign result.within_range = out_near_reg;

endmodule
